[design/refcounted_page_frame_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define RPFA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define RPFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/rpfa_pkg.sv]
// ----------------------------------------------------------------------------
// Page frame allocator package
// Field widths, request and status codes, and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package rpfa_pkg;

  // default sizing
  localparam int NUM_PAGES_DEF = 65536;
  localparam int REF_BITS_DEF  = 8;

  // fixed field widths
  localparam int REQ_W    = 3;
  localparam int PAGE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CNT_W    = 8;
  localparam int FREE_W   = 17;

  // request codes
  localparam logic [REQ_W-1:0] REQ_DONATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_RAISE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LOWER  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INUSE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVF   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd6;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // latch request, issue first memory reads
    logic clear;     // write one zero count during the reset sweep
    logic top_read;  // read the count of the page on top of the stack
    logic execute;   // update memories and register the result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;   // sweep is at the last count entry
    logic stack_empty;  // no page on the free stack
  } sts_t;

endpackage

`default_nettype wire

[design/rpfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/rpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// Page frame allocator controller
// Sequences the reset sweep and the read / execute steps of each request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_page_frame_allocator_macros.svh"

module rpfa_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rpfa_pkg::REQ_W-1:0] in_req_type,
  input  wire rpfa_pkg::sts_t             sts,
  output logic                            busy,
  output rpfa_pkg::cmd_t                  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLR,
    S_TOP,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   busy_r;

  // state and registered busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      busy_r  <= 1'b1;
    end else begin
      case (state_r)
        S_CLR: begin
          if (sts.clear_last) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end
        S_IDLE: begin
          if (start) begin
            busy_r <= 1'b1;
            if (in_req_type == rpfa_pkg::REQ_ALLOC && !sts.stack_empty) begin
              state_r <= S_TOP;
            end else begin
              state_r <= S_EXEC;
            end
          end
        end
        S_TOP: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  // commands
  assign busy         = busy_r;
  assign cmd.accept   = start && !busy_r;
  assign cmd.clear    = (state_r == S_CLR);
  assign cmd.top_read = (state_r == S_TOP);
  assign cmd.execute  = (state_r == S_EXEC);

  // checks
  `RPFA_ASSERT_NEXT(a_exec_releases, cmd.execute, !busy_r, "busy held after execute")
  `RPFA_ASSERT_SAME(a_top_after_accept, cmd.top_read, $past(cmd.accept), "top read without accept")
  `RPFA_ASSERT_NEXT(a_accept_busy, cmd.accept, busy_r && !cmd.accept, "accept not followed by busy")

endmodule

`default_nettype wire

[design/rpfa_dp.sv]
// ----------------------------------------------------------------------------
// Page frame allocator datapath
// Count table, free stack, depth counter, request decode and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_page_frame_allocator_macros.svh"

module rpfa_dp #(
  parameter int NUM_PAGES = rpfa_pkg::NUM_PAGES_DEF,
  parameter int REF_BITS  = rpfa_pkg::REF_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rpfa_pkg::cmd_t                cmd,
  output rpfa_pkg::sts_t                     sts,
  input  wire logic [rpfa_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [rpfa_pkg::PAGE_W-1:0]   in_page,
  input  wire logic                          cfg_we,
  input  wire logic [rpfa_pkg::PAGE_W-1:0]   cfg_wdata,
  output logic                               out_valid,
  output logic [rpfa_pkg::STATUS_W-1:0]      out_status,
  output logic [rpfa_pkg::PAGE_W-1:0]        out_result_page,
  output logic [rpfa_pkg::CNT_W-1:0]         out_ref_count,
  output logic [rpfa_pkg::FREE_W-1:0]        out_free_pages
);

  localparam int AW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int PW = rpfa_pkg::PAGE_W;

  // configuration and request registers
  logic [PW-1:0]                  first_page_r;
  logic [rpfa_pkg::REQ_W-1:0]     req_r;
  logic [PW-1:0]                  page_r;
  logic [DW-1:0]                  depth_r;
  logic [AW-1:0]                  clr_addr_r;

  // memory ports
  logic                ref_we;
  logic [AW-1:0]       ref_waddr;
  logic [REF_BITS-1:0] ref_wdata;
  logic                ref_re;
  logic [AW-1:0]       ref_raddr;
  logic [REF_BITS-1:0] cur;
  logic [PW-1:0]       top_page;
  logic [DW-1:0]       depth_dec;

  // execute decode
  logic                         in_range;
  logic                         may_free;
  logic                         can_push;
  logic                         top_bad;
  logic [REF_BITS-1:0]          raised;
  logic [rpfa_pkg::STATUS_W-1:0] st;
  logic [PW-1:0]                rpage;
  logic [REF_BITS-1:0]          cnt;
  logic                         upd;
  logic [AW-1:0]                upd_addr;
  logic [REF_BITS-1:0]          upd_val;
  logic                         push;
  logic                         pop;
  logic [rpfa_pkg::CNT_W+REF_BITS-1:0] cnt_ext;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
    end else if (cfg_we) begin
      first_page_r <= cfg_wdata;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= in_req_type;
      page_r <= in_page;
    end
  end

  // reset sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  assign sts.clear_last  = (clr_addr_r == AW'(NUM_PAGES - 1));
  assign sts.stack_empty = (depth_r == '0);

  // count table
  assign ref_re    = cmd.accept || cmd.top_read;
  assign ref_raddr = cmd.top_read ? top_page[AW-1:0] : in_page[AW-1:0];
  assign ref_we    = cmd.clear || (cmd.execute && upd);
  assign ref_waddr = cmd.clear ? clr_addr_r : upd_addr;
  assign ref_wdata = cmd.clear ? '0 : upd_val;

  rpfa_ram #(
    .WIDTH(REF_BITS),
    .DEPTH(NUM_PAGES)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(ref_waddr),
    .wdata(ref_wdata),
    .re   (ref_re),
    .raddr(ref_raddr),
    .rdata(cur)
  );

  // free stack, read at the top on accept
  assign depth_dec = depth_r - DW'(1);

  rpfa_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_PAGES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (cmd.execute && push),
    .waddr(depth_r[AW-1:0]),
    .wdata(page_r),
    .re   (cmd.accept),
    .raddr(depth_dec[AW-1:0]),
    .rdata(top_page)
  );

  // range checks
  assign in_range = ({1'b0, page_r} < (PW + 1)'(NUM_PAGES));
  assign may_free = in_range && (page_r >= first_page_r);
  assign can_push = (depth_r != DW'(NUM_PAGES));
  assign top_bad  = ({1'b0, top_page} >= (PW + 1)'(NUM_PAGES));
  assign raised   = (cur == '0) ? REF_BITS'(2) : cur + REF_BITS'(1);

  // request decode
  always_comb begin
    st       = rpfa_pkg::ST_OK;
    rpage    = page_r;
    cnt      = '0;
    upd      = 1'b0;
    upd_addr = page_r[AW-1:0];
    upd_val  = '0;
    push     = 1'b0;
    pop      = 1'b0;
    case (req_r)
      rpfa_pkg::REQ_DONATE: begin
        if (!may_free) begin
          st = rpfa_pkg::ST_BAD;
        end else if (!can_push) begin
          st  = rpfa_pkg::ST_FULL;
          cnt = cur;
        end else begin
          upd  = 1'b1;
          push = 1'b1;
        end
      end
      rpfa_pkg::REQ_FREE: begin
        if (!may_free) begin
          st = rpfa_pkg::ST_BAD;
        end else begin
          cnt = cur;
          if (cur == '0) begin
            st = rpfa_pkg::ST_ZERO;
          end else if (cur == REF_BITS'(1)) begin
            if (!can_push) begin
              st = rpfa_pkg::ST_FULL;
            end else begin
              upd  = 1'b1;
              push = 1'b1;
              cnt  = '0;
            end
          end else begin
            cnt     = cur - REF_BITS'(1);
            upd     = 1'b1;
            upd_val = cur - REF_BITS'(1);
          end
        end
      end
      rpfa_pkg::REQ_ALLOC: begin
        if (depth_r == '0) begin
          st    = rpfa_pkg::ST_EMPTY;
          rpage = '0;
        end else begin
          rpage = top_page;
          if (top_bad) begin
            st = rpfa_pkg::ST_BAD;
          end else if (cur != '0) begin
            st  = rpfa_pkg::ST_INUSE;
            cnt = cur;
          end else begin
            pop      = 1'b1;
            upd      = 1'b1;
            upd_addr = top_page[AW-1:0];
            upd_val  = REF_BITS'(1);
            cnt      = REF_BITS'(1);
          end
        end
      end
      rpfa_pkg::REQ_RAISE: begin
        if (!in_range) begin
          st = rpfa_pkg::ST_BAD;
        end else if (&cur) begin
          st  = rpfa_pkg::ST_OVF;
          cnt = cur;
        end else begin
          upd     = 1'b1;
          upd_val = raised;
          cnt     = raised;
        end
      end
      rpfa_pkg::REQ_LOWER: begin
        if (!in_range) begin
          st = rpfa_pkg::ST_BAD;
        end else if (cur == '0) begin
          st = rpfa_pkg::ST_ZERO;
        end else begin
          cnt     = cur - REF_BITS'(1);
          upd     = 1'b1;
          upd_val = cur - REF_BITS'(1);
        end
      end
      rpfa_pkg::REQ_READ: begin
        if (!in_range) begin
          st = rpfa_pkg::ST_BAD;
        end else begin
          cnt = cur;
        end
      end
      default: begin
        st = rpfa_pkg::ST_BAD;
      end
    endcase
  end

  // stack depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.execute && push) begin
      depth_r <= depth_r + DW'(1);
    end else if (cmd.execute && pop) begin
      depth_r <= depth_dec;
    end
  end

  // result register
  assign cnt_ext = {{rpfa_pkg::CNT_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.execute;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status      <= st;
      out_result_page <= rpage;
      out_ref_count   <= cnt_ext[rpfa_pkg::CNT_W-1:0];
      out_free_pages  <= rpfa_pkg::FREE_W'(depth_r + DW'(push) - DW'(pop));
    end
  end

  // checks
  `RPFA_ASSERT_NEXT(a_push_depth, cmd.execute && push, depth_r == $past(depth_r) + DW'(1), "push lost")
  `RPFA_ASSERT_NEXT(a_pop_depth, cmd.execute && pop, depth_r == $past(depth_r) - DW'(1), "pop lost")
  `RPFA_ASSERT_SAME(a_result_depth, out_valid, out_free_pages == rpfa_pkg::FREE_W'(depth_r), "stale depth")

endmodule

`default_nettype wire

[design/refcounted_page_frame_allocator.sv]
// Sequence: accept, execute, registered result strobe. An allocate that finds the stack
// non-empty adds a top-read state: it reads the stack top first, then that page's count.
// Busy stays high through execute, so no new request is taken before the last is done;
// every request reads a count from the table RAM; a changed count is written in execute.
// Reset: a sweep clears every count table entry with busy high; config writes
// are taken during it. Results are strobed for one cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// Reference counted page frame allocator
// LIFO free page stack with a per-page reference count table.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_page_frame_allocator #(
  parameter int NUM_PAGES = rpfa_pkg::NUM_PAGES_DEF,
  parameter int REF_BITS  = rpfa_pkg::REF_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [rpfa_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [rpfa_pkg::PAGE_W-1:0]     in_page,
  input  wire logic                            cfg_we,
  input  wire logic [rpfa_pkg::PAGE_W-1:0]     cfg_wdata,
  output logic                                 out_valid,
  output logic [rpfa_pkg::STATUS_W-1:0]        out_status,
  output logic [rpfa_pkg::PAGE_W-1:0]          out_result_page,
  output logic [rpfa_pkg::CNT_W-1:0]           out_ref_count,
  output logic [rpfa_pkg::FREE_W-1:0]          out_free_pages
);

  rpfa_pkg::cmd_t cmd;
  rpfa_pkg::sts_t sts;

  // sequencing
  rpfa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_req_type(in_req_type),
    .sts        (sts),
    .busy       (busy),
    .cmd        (cmd)
  );

  // tables and result path
  rpfa_dp #(
    .NUM_PAGES(NUM_PAGES),
    .REF_BITS (REF_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_page        (in_page),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_result_page(out_result_page),
    .out_ref_count  (out_ref_count),
    .out_free_pages (out_free_pages)
  );

endmodule

`default_nettype wire

[tb/tb_refcounted_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// Page frame allocator testbench
// Drives page requests through the start/busy command port and checks every
// strobed result against a cycle-free predictor of the count table and free
// stack. A table of directed requests comes first. Random phases follow, each
// under its own first_page setting. A long run of increments then drives one
// count into overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_refcounted_page_frame_allocator;

  localparam int NUM_PAGES  = 65536;
  localparam int COUNT_MAX  = 255;
  localparam int POOL_SIZE  = 12;
  localparam int PHASE_REQS = 150;
  localparam int IDLE_LIMIT = 4 * NUM_PAGES;
  localparam int SHOW_MAX   = 10;

  // request codes the block does not define
  localparam logic [rpfa_pkg::REQ_W-1:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [rpfa_pkg::REQ_W-1:0] REQ_UNDEF_HI = 3'd7;

  typedef struct packed {
    logic [rpfa_pkg::STATUS_W-1:0] status;
    logic [rpfa_pkg::PAGE_W-1:0]   page;
    logic [rpfa_pkg::CNT_W-1:0]    count;
    logic [rpfa_pkg::FREE_W-1:0]   free;
  } frame_result_t;

  typedef struct packed {
    logic [rpfa_pkg::REQ_W-1:0]  req;
    logic [rpfa_pkg::PAGE_W-1:0] page;
    logic                        typed;
    frame_result_t               want;
  } stim_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [rpfa_pkg::REQ_W-1:0]    in_req_type = '0;
  logic [rpfa_pkg::PAGE_W-1:0]   in_page = '0;
  logic                          cfg_we = 1'b0;
  logic [rpfa_pkg::PAGE_W-1:0]   cfg_wdata = '0;
  logic                          out_valid;
  logic [rpfa_pkg::STATUS_W-1:0] out_status;
  logic [rpfa_pkg::PAGE_W-1:0]   out_result_page;
  logic [rpfa_pkg::CNT_W-1:0]    out_ref_count;
  logic [rpfa_pkg::FREE_W-1:0]   out_free_pages;

  // predictor state
  logic [rpfa_pkg::CNT_W-1:0]  page_refs [NUM_PAGES];
  logic [rpfa_pkg::PAGE_W-1:0] free_list [NUM_PAGES];
  int                          free_depth = 0;
  logic [rpfa_pkg::PAGE_W-1:0] lowest_page = '0;

  frame_result_t               due_replies [$];
  logic [rpfa_pkg::PAGE_W-1:0] page_pool [POOL_SIZE];

  int burst_left = 0;
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int stack_peak = 0;
  int idle_cycles = 0;
  int status_hits [8];

  // directed requests, first_page is 16 while they run
  stim_row_t directed_rows [25] = '{
    '{rpfa_pkg::REQ_ALLOC,  16'h0000, 1'b1, '{rpfa_pkg::ST_EMPTY, 16'h0000, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_READ,   16'hFFFF, 1'b1, '{rpfa_pkg::ST_OK,    16'hFFFF, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_FREE,   16'h0020, 1'b1, '{rpfa_pkg::ST_ZERO,  16'h0020, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_LOWER,  16'h0020, 1'b1, '{rpfa_pkg::ST_ZERO,  16'h0020, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_DONATE, 16'h000F, 1'b1, '{rpfa_pkg::ST_BAD,   16'h000F, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_FREE,   16'h0000, 1'b1, '{rpfa_pkg::ST_BAD,   16'h0000, 8'd0, 17'd0}},
    '{REQ_UNDEF_LO,         16'hAAAA, 1'b1, '{rpfa_pkg::ST_BAD,   16'hAAAA, 8'd0, 17'd0}},
    '{REQ_UNDEF_HI,         16'h5555, 1'b1, '{rpfa_pkg::ST_BAD,   16'h5555, 8'd0, 17'd0}},
    '{rpfa_pkg::REQ_DONATE, 16'h0010, 1'b1, '{rpfa_pkg::ST_OK,    16'h0010, 8'd0, 17'd1}},
    '{rpfa_pkg::REQ_DONATE, 16'hFFFF, 1'b1, '{rpfa_pkg::ST_OK,    16'hFFFF, 8'd0, 17'd2}},
    '{rpfa_pkg::REQ_RAISE,  16'hFFFF, 1'b1, '{rpfa_pkg::ST_OK,    16'hFFFF, 8'd2, 17'd2}},
    '{rpfa_pkg::REQ_ALLOC,  16'h1234, 1'b1, '{rpfa_pkg::ST_INUSE, 16'hFFFF, 8'd2, 17'd2}},
    '{rpfa_pkg::REQ_LOWER,  16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_LOWER,  16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'hEDCB, 1'b0, '0},
    '{rpfa_pkg::REQ_RAISE,  16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_FREE,   16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_FREE,   16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'h0000, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'hFFFF, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'h0000, 1'b0, '0},
    '{rpfa_pkg::REQ_DONATE, 16'h0010, 1'b0, '0},
    '{rpfa_pkg::REQ_DONATE, 16'h0010, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'h0000, 1'b0, '0},
    '{rpfa_pkg::REQ_ALLOC,  16'h0000, 1'b0, '0}
  };

  refcounted_page_frame_allocator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_page         (in_page),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_page (out_result_page),
    .out_ref_count   (out_ref_count),
    .out_free_pages  (out_free_pages)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // outcome of one request, updates the predicted table and stack
  function automatic frame_result_t allocator_outcome(
      input logic [rpfa_pkg::REQ_W-1:0] req,
      input logic [rpfa_pkg::PAGE_W-1:0] pg);
    frame_result_t               r;
    int                          cnt;
    int                          nxt;
    logic [rpfa_pkg::PAGE_W-1:0] top;
    logic                        in_range;
    logic                        may_free;
    in_range = int'(pg) < NUM_PAGES;
    may_free = in_range && (pg >= lowest_page);
    r.status = rpfa_pkg::ST_OK;
    r.page   = pg;
    cnt      = 0;
    case (req)
      rpfa_pkg::REQ_DONATE: begin
        if (!may_free) begin
          r.status = rpfa_pkg::ST_BAD;
        end else if (free_depth >= NUM_PAGES) begin
          r.status = rpfa_pkg::ST_FULL;
          cnt = page_refs[pg];
        end else begin
          page_refs[pg] = '0;
          free_list[free_depth] = pg;
          free_depth++;
        end
      end
      rpfa_pkg::REQ_FREE: begin
        if (!may_free) begin
          r.status = rpfa_pkg::ST_BAD;
        end else begin
          cnt = page_refs[pg];
          if (cnt == 0) begin
            r.status = rpfa_pkg::ST_ZERO;
          end else if (cnt == 1) begin
            if (free_depth >= NUM_PAGES) begin
              r.status = rpfa_pkg::ST_FULL;
            end else begin
              page_refs[pg] = '0;
              free_list[free_depth] = pg;
              free_depth++;
              cnt = 0;
            end
          end else begin
            cnt--;
            page_refs[pg] = cnt[rpfa_pkg::CNT_W-1:0];
          end
        end
      end
      rpfa_pkg::REQ_ALLOC: begin
        if (free_depth == 0) begin
          r.status = rpfa_pkg::ST_EMPTY;
          r.page = '0;
        end else begin
          top = free_list[free_depth-1];
          r.page = top;
          if (page_refs[top] != 0) begin
            // top page still referenced, stays on the stack
            r.status = rpfa_pkg::ST_INUSE;
            cnt = page_refs[top];
          end else begin
            free_depth--;
            page_refs[top] = 8'd1;
            cnt = 1;
          end
        end
      end
      rpfa_pkg::REQ_RAISE: begin
        if (!in_range) begin
          r.status = rpfa_pkg::ST_BAD;
        end else begin
          cnt = page_refs[pg];
          nxt = (cnt == 0) ? 2 : cnt + 1;
          if (nxt > COUNT_MAX) begin
            r.status = rpfa_pkg::ST_OVF;
          end else begin
            page_refs[pg] = nxt[rpfa_pkg::CNT_W-1:0];
            cnt = nxt;
          end
        end
      end
      rpfa_pkg::REQ_LOWER: begin
        if (!in_range) begin
          r.status = rpfa_pkg::ST_BAD;
        end else begin
          cnt = page_refs[pg];
          if (cnt == 0) begin
            r.status = rpfa_pkg::ST_ZERO;
          end else begin
            cnt--;
            page_refs[pg] = cnt[rpfa_pkg::CNT_W-1:0];
          end
        end
      end
      rpfa_pkg::REQ_READ: begin
        if (!in_range) r.status = rpfa_pkg::ST_BAD;
        else cnt = page_refs[pg];
      end
      default: r.status = rpfa_pkg::ST_BAD;
    endcase
    r.count = cnt[rpfa_pkg::CNT_W-1:0];
    r.free  = free_depth[rpfa_pkg::FREE_W-1:0];
    if (free_depth > stack_peak) stack_peak = free_depth;
    return r;
  endfunction

  // one request transaction; the sender pauses between bursts
  task automatic issue_request(input logic [rpfa_pkg::REQ_W-1:0] req,
                               input logic [rpfa_pkg::PAGE_W-1:0] pg,
                               input logic typed, input frame_result_t want);
    frame_result_t predicted;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_req_type <= req;
    in_page     <= pg;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = allocator_outcome(req, pg);
    due_replies.push_back(typed ? want : predicted);
    requests_sent++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_requests();
    start <= 1'b0;
    while (due_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_first_page(input logic [rpfa_pkg::PAGE_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    lowest_page = value;
    settings_used++;
  endtask

  // working set of pages near first_page, with a few strays
  task automatic refill_pool();
    int v;
    for (int i = 0; i < POOL_SIZE; i++) begin
      v = int'(lowest_page) + $urandom_range(0, 31);
      if (v > NUM_PAGES - 1) v = NUM_PAGES - 1;
      page_pool[i] = v[rpfa_pkg::PAGE_W-1:0];
      if (i % 6 == 4) page_pool[i] = 16'($urandom);
      if (i % 6 == 5 && lowest_page != 0) page_pool[i] = lowest_page - 16'd1;
    end
  endtask

  task automatic random_request();
    int                          pick;
    logic [rpfa_pkg::REQ_W-1:0]  req;
    logic [rpfa_pkg::PAGE_W-1:0] pg;
    pick = $urandom_range(0, 99);
    pg = ($urandom_range(0, 99) < 85) ? page_pool[$urandom_range(0, POOL_SIZE-1)]
                                      : 16'($urandom);
    if (pick < 14)      req = rpfa_pkg::REQ_DONATE;
    else if (pick < 28) req = rpfa_pkg::REQ_FREE;
    else if (pick < 48) req = rpfa_pkg::REQ_ALLOC;
    else if (pick < 66) req = rpfa_pkg::REQ_RAISE;
    else if (pick < 78) req = rpfa_pkg::REQ_LOWER;
    else if (pick < 90) req = rpfa_pkg::REQ_READ;
    else if (pick < 95) req = ($urandom_range(0, 1) == 0) ? REQ_UNDEF_LO : REQ_UNDEF_HI;
    else begin
      req = 3'($urandom_range(0, 7));
      pg  = 16'($urandom);
    end
    issue_request(req, pg, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    string         fields;
    if (rst_n && out_valid === 1'b1) begin
      got = '{out_status, out_result_page, out_ref_count, out_free_pages};
      if (due_replies.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected result: status %0d page %h count %0d free %0d",
                   got.status, got.page, got.count, got.free);
      end else begin
        want = due_replies.pop_front();
        results_checked++;
        status_hits[got.status]++;
        if (got !== want) begin
          fields = "";
          if (got.status !== want.status) fields = {fields, " status"};
          if (got.page !== want.page)     fields = {fields, " page"};
          if (got.count !== want.count)   fields = {fields, " count"};
          if (got.free !== want.free)     fields = {fields, " free"};
          errors++;
          if (errors <= SHOW_MAX)
            $display("mismatch at %0t on%s: want %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                     $realtime, fields, want.status, want.page, want.count, want.free,
                     got.status, got.page, got.count, got.free);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [rpfa_pkg::PAGE_W-1:0] phase_first [5];
    logic [rpfa_pkg::PAGE_W-1:0] target;
    foreach (page_refs[i]) page_refs[i] = '0;
    foreach (status_hits[i]) status_hits[i] = 0;
    phase_first = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h8000, 16'($urandom)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_first_page(16'h0010);

    // directed table
    foreach (directed_rows[i])
      issue_request(directed_rows[i].req, directed_rows[i].page,
                    directed_rows[i].typed, directed_rows[i].want);

    // random phases, one first_page setting each, with a full pause midway
    foreach (phase_first[p]) begin
      drain_requests();
      write_first_page(phase_first[p]);
      refill_pool();
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n == PHASE_REQS / 2) drain_requests();
        random_request();
      end
    end

    // push one count past its top
    target = 16'($urandom);
    for (int n = 0; n < COUNT_MAX + 4; n++)
      issue_request(rpfa_pkg::REQ_RAISE, target, 1'b0, '0);
    for (int n = 0; n < 3; n++) issue_request(rpfa_pkg::REQ_LOWER, target, 1'b0, '0);

    drain_requests();
    repeat (4) @(posedge clk);

    $display("%0d requests under %0d first_page settings, %0d results checked, stack peak %0d",
             requests_sent, settings_used, results_checked, stack_peak);
    $display("status mix: ok %0d empty %0d bad %0d zero %0d in-use %0d overflow %0d full %0d",
             status_hits[rpfa_pkg::ST_OK], status_hits[rpfa_pkg::ST_EMPTY],
             status_hits[rpfa_pkg::ST_BAD], status_hits[rpfa_pkg::ST_ZERO],
             status_hits[rpfa_pkg::ST_INUSE], status_hits[rpfa_pkg::ST_OVF],
             status_hits[rpfa_pkg::ST_FULL]);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
